FILE: rtl/core/multi_reader_ring_buffer_assert.svh
// Assertion macros for the multi-reader ring buffer
`ifndef MULTI_READER_RING_BUFFER_ASSERT_SVH
`define MULTI_READER_RING_BUFFER_ASSERT_SVH
// assert that a condition implies a consequent in the same cycle
`define MRRB_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a condition implies a consequent in the next cycle
`define MRRB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/mrrb_pkg.sv
// ----------------------------------------------------------------------------
// mrrb_pkg
// Types, codes and defaults shared by the ring buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mrrb_pkg;
  localparam int DEF_RING_DEPTH  = 65536;
  localparam int DEF_NUM_READERS = 8;
  localparam int DEF_MAX_READ    = 64;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_ATTACH = 3'd2;
  localparam logic [2:0] CMD_BACKP  = 3'd3;
  localparam logic [2:0] CMD_REPORT = 3'd4;

  localparam logic [2:0] ST_WRITTEN  = 3'd0;
  localparam logic [2:0] ST_DATA     = 3'd1;
  localparam logic [2:0] ST_SYNC     = 3'd2;
  localparam logic [2:0] ST_NODATA   = 3'd3;
  localparam logic [2:0] ST_OVERRUN  = 3'd4;
  localparam logic [2:0] ST_BACKPRES = 3'd5;
  localparam logic [2:0] ST_ACK      = 3'd6;

  localparam logic [1:0] REG_RING_SIZE = 2'd0;
  localparam logic [1:0] REG_ALIGN     = 2'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [2:0] reader;
    logic [6:0] request_len;
    logic       clear_gauges;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte_res;
    logic        last;
    logic [6:0]  copy_len;
    logic [16:0] reader_backlog;
    logic [15:0] max_backlog;
    logic [31:0] overrun_tally;
    logic [31:0] backpressure_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DIV, S_EMIT, S_STREAM, S_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic eval;      // compute diff, pos, ready
    logic decide;    // apply state updates for a command
    logic div_step;  // one alignment step
    logic rd_issue;  // issue memory read
    logic single;    // form single result
    logic advance;   // next stream byte
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic known;
    logic stream;    // read will stream data
    logic need_div;
    logic div_done;
    logic stream_end;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/mrrb_stream_if.sv
// ----------------------------------------------------------------------------
// mrrb_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface mrrb_stream_if #(parameter int W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/multi_reader_ring_buffer.sv
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer
// Single-writer byte ring with independent readers and overrun resync.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (valid/ready), results leave on out_ch.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// The block takes one item at a time: accept, evaluate, decide. A
// single-result command is then formed in the emit state and pushed into the
// output register; an ignored command code gives no result.
// With alignment on, a data read adds one subtract step per multiple of
// align_bytes in its clamped length, before the decide step.
// A data read streams one byte per cycle from the single-port ring memory
// while the receiver keeps up, copy_len results in all.
// Results sit in an output register: a stalled receiver holds the block in
// its emit states, so no input is taken until the result is pushed; the last
// result may still wait in the register when the next item is taken.
// Reset (rst, synchronous) clears heads, counters, readers and gauges;
// ring contents are undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_reader_ring_buffer #(
  parameter int RING_DEPTH  = mrrb_pkg::DEF_RING_DEPTH,
  parameter int NUM_READERS = mrrb_pkg::DEF_NUM_READERS,
  parameter int MAX_READ    = mrrb_pkg::DEF_MAX_READ
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [16:0] cfg_data,
  mrrb_stream_if.sink     in_ch,
  mrrb_stream_if.source   out_ch
);
  import mrrb_pkg::*;
  `include "multi_reader_ring_buffer_assert.svh"
  ctrl_t ctl;
  stat_t st;
  out_item_t res;
  out_item_t out_q;
  logic out_v, push, in_rdy;

  assign in_ch.ready = in_rdy;
  assign out_ch.valid = out_v;
  assign out_ch.payload = out_q;

  mrrb_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_rdy),
    .out_push(push), .out_free(!out_v || out_ch.ready), .st(st), .ctl(ctl));

  mrrb_datapath #(.RING_DEPTH(RING_DEPTH), .NUM_READERS(NUM_READERS),
    .MAX_READ(MAX_READ)) u_dp (.clk(clk), .rst(rst), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_item(in_ch.payload),
    .ctl(ctl), .st(st), .res(res));

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (push) out_v <= 1'b1;
    else if (out_ch.ready) out_v <= 1'b0;
    if (push) out_q <= res;
  end

  `MRRB_ASSERT_IMPL(a_push_free, clk, rst, push && out_v, out_ch.ready)
  `MRRB_ASSERT_NEXT(a_push_valid, clk, rst, push, out_v)
  `MRRB_ASSERT_IMPL(a_no_accept_busy, clk, rst, in_rdy, !push)
endmodule
`default_nettype wire

FILE: rtl/core/mrrb_ctrl.sv
// ----------------------------------------------------------------------------
// mrrb_ctrl
// Command sequencer: accepts an item, steps evaluation and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module mrrb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_push,
  input  wire logic            out_free,
  input  wire mrrb_pkg::stat_t st,
  output mrrb_pkg::ctrl_t      ctl
);
  import mrrb_pkg::*;
  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_push = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (st.need_div && !st.div_done) ctl.div_step = 1'b1;
        else begin
          ctl.decide = 1'b1;
          if (!st.known) state_next = S_IDLE;
          else if (st.stream) begin
            ctl.rd_issue = 1'b1;
            state_next = S_STREAM;
          end else state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.single = 1'b1;
          out_push = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        if (out_free) begin
          out_push = 1'b1;
          ctl.advance = 1'b1;
          if (st.stream_end) state_next = S_IDLE;
          else ctl.rd_issue = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/mrrb_datapath.sv
// ----------------------------------------------------------------------------
// mrrb_datapath
// Ring memory, reader table, gauges and result formation.
// ----------------------------------------------------------------------------
`default_nettype none
module mrrb_datapath #(
  parameter int RING_DEPTH  = 65536,
  parameter int NUM_READERS = 8,
  parameter int MAX_READ    = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_data,
  input  wire mrrb_pkg::in_item_t  in_item,
  input  wire mrrb_pkg::ctrl_t     ctl,
  output mrrb_pkg::stat_t          st,
  output mrrb_pkg::out_item_t      res
);
  import mrrb_pkg::*;
  localparam int AW = $clog2(RING_DEPTH);
  localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int SW = AW + 1;

  logic [7:0]    mem [RING_DEPTH];
  logic [SW-1:0] ring_size;
  logic [6:0]    align;
  logic [AW-1:0] write_head;
  logic [47:0]   byte_total;
  logic [NUM_READERS-1:0] unsynced;
  logic [AW-1:0] rpos [NUM_READERS];
  logic [47:0]   rseen [NUM_READERS];
  logic [15:0]   max_bl;
  logic [31:0]   ovr_total, bp_total;

  in_item_t      it;
  logic          rvalid;
  logic [RW-1:0] ri;
  logic [47:0]   diff;
  logic [AW-1:0] pos;
  logic [6:0]    copy, rem, cnt;
  logic [6:0]    quot_acc;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] fetch_addr;
  logic [AW-1:0] fetch_next;
  logic [7:0]    rd_data;
  logic [2:0]    sstat;

  // clamp a configured ring size
  function automatic logic [SW-1:0] clamp(input logic [16:0] v);
    if (v == 17'd0) return SW'(1);
    if (32'(v) > RING_DEPTH) return SW'(RING_DEPTH);
    return SW'(v);
  endfunction

  // backlog of reader index r, clamped
  function automatic logic [16:0] backlog(input logic [2:0] r, input logic [47:0] tot,
                                          input logic [47:0] seen, input logic uns,
                                          input logic [SW-1:0] rs);
    logic [47:0] d;
    d = tot - seen;
    if (32'(r) >= NUM_READERS || uns) return 17'd0;
    if (d > 48'(rs)) return 17'(rs);
    return d[16:0];
  endfunction

  assign ri = RW'(it.reader);
  assign rvalid = 32'(it.reader) < NUM_READERS;

  // status to controller
  always_comb begin
    st.is_read = it.command == CMD_READ;
    st.known = it.command <= CMD_REPORT;
    st.need_div = st.is_read && rvalid && !unsynced[ri] && align != 7'd0
                  && sstat == ST_DATA;
    st.div_done = rem < align;
    st.stream = st.is_read && sstat == ST_DATA && (align == 7'd0 ? copy : quot_acc)
                != 7'd0;
    st.stream_end = cnt == 7'd1;
  end

  // fetch the start position on decide, else the running address
  always_comb begin
    fetch_addr = ctl.decide ? pos : rd_addr;
    fetch_next = (SW'(fetch_addr) + SW'(1) >= ring_size) ? '0 : fetch_addr + AW'(1);
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (ctl.load && in_item.command == CMD_WRITE) mem[write_head] <= in_item.data_byte;
    if (ctl.rd_issue) begin
      rd_data <= mem[fetch_addr];
      rd_addr <= fetch_next;
    end
  end

  // main state
  always_ff @(posedge clk) begin
    logic [SW-1:0] np;
    if (ctl.load) it <= in_item;
    if (rst) begin
      ring_size <= clamp(17'd65536);
      align <= 7'd0;
      write_head <= '0;
      byte_total <= '0;
      unsynced <= '1;
      for (int i = 0; i < NUM_READERS; i++) begin
        rpos[i] <= '0;
        rseen[i] <= '0;
      end
      max_bl <= '0;
      ovr_total <= '0;
      bp_total <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_RING_SIZE) begin
        ring_size <= clamp(cfg_data);
        write_head <= '0;
        byte_total <= '0;
      end
      if (cfg_we && cfg_index == REG_ALIGN) align <= cfg_data[6:0];
      // write command
      if (ctl.load && in_item.command == CMD_WRITE) begin
        np = SW'(write_head) + SW'(1);
        write_head <= (np >= ring_size) ? '0 : np[AW-1:0];
        byte_total <= byte_total + 48'd1;
      end
      // evaluate read
      if (ctl.eval) begin
        diff <= byte_total - rseen[ri];
        pos <= (SW'(rpos[ri]) >= ring_size) ? '0 : rpos[ri];
      end
      if (ctl.decide) begin
        case (it.command)
          CMD_READ: begin
            if (rvalid && unsynced[ri]) begin
              rpos[ri] <= write_head;
              rseen[ri] <= byte_total;
              unsynced[ri] <= 1'b0;
            end else if (rvalid && sstat == ST_OVERRUN) begin
              ovr_total <= ovr_total + 32'd1;
              rpos[ri] <= write_head;
              rseen[ri] <= byte_total;
            end else if (rvalid && sstat == ST_DATA) begin
              if (diff > 48'(max_bl)) max_bl <= (diff > 48'hFFFF) ? 16'hFFFF : diff[15:0];
              rseen[ri] <= byte_total;
              rpos[ri] <= pos;
            end else if (rvalid) rpos[ri] <= pos;
          end
          CMD_ATTACH: begin
            if (rvalid) begin
              unsynced[ri] <= 1'b1;
              rpos[ri] <= '0;
              rseen[ri] <= '0;
            end
          end
          CMD_BACKP: bp_total <= bp_total + 32'd1;
          default: ;
        endcase
      end
      if (ctl.single && it.command == CMD_REPORT && it.clear_gauges) begin
        max_bl <= '0;
        bp_total <= '0;
      end
      // advance reader position once per streamed byte
      if (ctl.advance) begin
        np = SW'(rpos[ri]) + SW'(1);
        rpos[ri] <= (np >= ring_size) ? '0 : np[AW-1:0];
      end
    end
  end

  // read evaluation pipeline: sstat, copy, alignment steps, stream count
  always_ff @(posedge clk) begin
    logic [6:0] req;
    logic [SW-1:0] rdy;
    logic [47:0] d;
    logic [AW-1:0] p;
    if (ctl.eval) begin
      d = byte_total - rseen[ri];
      p = (SW'(rpos[ri]) >= ring_size) ? '0 : rpos[ri];
      rdy = (p < write_head) ? SW'(write_head) - SW'(p) : ring_size - SW'(p) + SW'(write_head);
      req = (32'(it.request_len) > MAX_READ) ? 7'(MAX_READ) : it.request_len;
      copy <= (rdy < SW'(req)) ? rdy[6:0] : req;
      rem <= (rdy < SW'(req)) ? rdy[6:0] : req;
      quot_acc <= '0;
      if (!rvalid) sstat <= ST_NODATA;
      else if (unsynced[ri]) sstat <= ST_SYNC;
      else if (p == write_head && d == 48'd0) sstat <= ST_NODATA;
      else if (d >= 48'(ring_size)) sstat <= ST_OVERRUN;
      else sstat <= ST_DATA;
    end
    // subtract one alignment multiple
    if (ctl.div_step) begin
      rem <= rem - align;
      quot_acc <= quot_acc + align;
    end
    if (ctl.decide) cnt <= (align == 7'd0) ? copy : quot_acc;
    if (ctl.decide && (align != 7'd0)) copy <= quot_acc;
    if (ctl.advance) cnt <= cnt - 7'd1;
  end

  // result formation
  always_comb begin
    logic [2:0] s;
    res = '0;
    res.last = 1'b1;
    res.reader_backlog = backlog(it.reader, byte_total, rseen[ri], unsynced[ri], ring_size);
    res.max_backlog = max_bl;
    res.overrun_tally = ovr_total;
    res.backpressure_count = bp_total;
    case (it.command)
      CMD_WRITE:  s = ST_WRITTEN;
      CMD_READ:   s = (sstat == ST_DATA) ? ST_NODATA : sstat;
      CMD_BACKP:  s = ST_BACKPRES;
      default:    s = ST_ACK;
    endcase
    res.status = s;
    if (!ctl.single) begin
      res.status = ST_DATA;
      res.data_byte_res = rd_data;
      res.last = cnt == 7'd1;
      res.copy_len = copy;
    end
  end
endmodule
`default_nettype wire

FILE: verif/multi_reader_ring_buffer_tb.sv
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer_tb
// Self-checking bench for the multi-reader byte ring. A directed table runs
// at the reset settings, then random commands over several ring size and
// alignment settings. A predictor in the bench tracks the ring, readers and
// gauges; each result is checked field by field against it or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_reader_ring_buffer_tb;
  import mrrb_pkg::*;

  localparam int DEPTH     = 65536;
  localparam int READERS   = 8;
  localparam int READ_MAX  = 64;
  localparam int WDOG_LIM  = 3000;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t exp;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  mrrb_stream_if #(.W($bits(in_item_t)))  in_ch (clk);
  mrrb_stream_if #(.W($bits(out_item_t))) out_ch (clk);

  multi_reader_ring_buffer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // ring and reader shadow state
  logic [7:0]  ring_mem [DEPTH];
  bit          ring_written [DEPTH];
  logic [16:0] ring_len;
  logic [6:0]  align_len;
  logic [15:0] head;
  logic [47:0] byte_cnt;
  bit          unsynced [READERS];
  logic [15:0] rd_pos [READERS];
  logic [47:0] rd_seen [READERS];
  logic [15:0] hiwater;
  logic [31:0] overruns;
  logic [31:0] bp_events;

  out_item_t result_q [$];
  out_item_t staged_q [$];
  row_t      dir_tbl [$];
  int        errors;
  bit        idle_en;
  bit        hold_req;
  int        hold_cnt;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] backlog_of(int r);
    logic [47:0] d;
    if (unsynced[r]) return 17'd0;
    d = byte_cnt - rd_seen[r];
    if (d > {31'd0, ring_len}) return ring_len;
    return d[16:0];
  endfunction

  function automatic void stage(logic [2:0] st, logic [7:0] b, bit lst, logic [6:0] cl,
                                int r);
    out_item_t o;
    o.status             = st;
    o.data_byte_res      = b;
    o.last               = lst;
    o.copy_len           = cl;
    o.reader_backlog     = backlog_of(r);
    o.max_backlog        = hiwater;
    o.overrun_tally      = overruns;
    o.backpressure_count = bp_events;
    staged_q.push_back(o);
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [16:0] val);
    if (idx == REG_RING_SIZE) begin
      ring_len = (val == 0) ? 17'd1 : (val > DEPTH) ? 17'(DEPTH) : val;
      head     = '0;
      byte_cnt = '0;
    end else if (idx == REG_ALIGN) begin
      align_len = val[6:0];
    end
  endfunction

  // Work out the results of one command; flag reads of unwritten entries.
  function automatic void predict(in_item_t it, output bit unsafe);
    int          r;
    int          pos;
    int          rdy;
    int          req;
    int          cnt;
    int          idx;
    int          nxt;
    logic [47:0] diff;
    logic [7:0]  bytes [$];
    r      = int'(it.reader);
    unsafe = 0;
    staged_q.delete();
    case (it.command)
      CMD_WRITE: begin
        ring_mem[head]     = it.data_byte;
        ring_written[head] = 1;
        nxt = int'(head) + 1;
        head = (nxt >= ring_len) ? 16'd0 : 16'(nxt);
        byte_cnt = byte_cnt + 48'd1;
        stage(ST_WRITTEN, 8'd0, 1, 7'd0, r);
      end
      CMD_READ: begin
        if (unsynced[r]) begin
          rd_pos[r]   = head;
          rd_seen[r]  = byte_cnt;
          unsynced[r] = 0;
          stage(ST_SYNC, 8'd0, 1, 7'd0, r);
          return;
        end
        diff = byte_cnt - rd_seen[r];
        pos  = int'(rd_pos[r]);
        if (pos >= ring_len) pos = 0;
        if (pos == head && diff == 0) begin
          rd_pos[r] = 16'(pos);
          stage(ST_NODATA, 8'd0, 1, 7'd0, r);
          return;
        end
        if (diff >= {31'd0, ring_len}) begin
          overruns   = overruns + 32'd1;
          rd_pos[r]  = head;
          rd_seen[r] = byte_cnt;
          stage(ST_OVERRUN, 8'd0, 1, 7'd0, r);
          return;
        end
        if (diff > {32'd0, hiwater}) hiwater = (diff > 48'hFFFF) ? 16'hFFFF : diff[15:0];
        rdy = (pos < head) ? int'(head) - pos : int'(ring_len) - pos + int'(head);
        req = (it.request_len > READ_MAX) ? READ_MAX : int'(it.request_len);
        cnt = (rdy < req) ? rdy : req;
        if (align_len > 0) cnt = cnt / int'(align_len) * int'(align_len);
        rd_seen[r] = byte_cnt;
        if (cnt == 0) begin
          rd_pos[r] = 16'(pos);
          stage(ST_NODATA, 8'd0, 1, 7'd0, r);
          return;
        end
        for (int i = 0; i < cnt; i++) begin
          idx = pos + i;
          if (idx >= ring_len) idx -= int'(ring_len);
          if (!ring_written[idx]) unsafe = 1;
          bytes.push_back(ring_mem[idx]);
        end
        pos += cnt;
        if (pos >= ring_len) pos -= int'(ring_len);
        rd_pos[r] = 16'(pos);
        foreach (bytes[i]) stage(ST_DATA, bytes[i], i == cnt - 1, 7'(cnt), r);
      end
      CMD_ATTACH: begin
        unsynced[r] = 1;
        rd_pos[r]   = '0;
        rd_seen[r]  = '0;
        stage(ST_ACK, 8'd0, 1, 7'd0, r);
      end
      CMD_BACKP: begin
        bp_events = bp_events + 32'd1;
        stage(ST_BACKPRES, 8'd0, 1, 7'd0, r);
      end
      CMD_REPORT: begin
        stage(ST_ACK, 8'd0, 1, 7'd0, r);
        if (it.clear_gauges) begin
          hiwater   = '0;
          bp_events = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk(logic [2:0] c, logic [7:0] b, logic [2:0] r,
                                  logic [6:0] q, bit g);
    in_item_t it;
    it.command      = c;
    it.data_byte    = b;
    it.reader       = r;
    it.request_len  = q;
    it.clear_gauges = g;
    return it;
  endfunction

  function automatic in_item_t rand_cmd();
    int       w;
    int       q;
    in_item_t it;
    w = $urandom_range(0, 99);
    q = $urandom_range(0, 9);
    it = mk(CMD_WRITE, 8'($urandom), 3'($urandom), 7'($urandom_range(1, 16)),
            1'($urandom));
    if (q == 0) it.request_len = 7'd0;
    else if (q == 1) it.request_len = 7'($urandom_range(17, READ_MAX));
    else if (q == 2) it.request_len = 7'($urandom_range(READ_MAX + 1, 127));
    if (w < 50) it.command = CMD_WRITE;
    else if (w < 80) it.command = CMD_READ;
    else if (w < 85) it.command = CMD_ATTACH;
    else if (w < 90) it.command = CMD_BACKP;
    else if (w < 96) it.command = CMD_REPORT;
    else it.command = 3'($urandom_range(5, 7));
    return it;
  endfunction

  // Offer one transaction; a read that would touch unwritten entries
  // becomes a write of the same reader instead.
  task automatic send(input in_item_t it, input bit typed, input out_item_t texp);
    bit          unsafe;
    int          r;
    int          n;
    logic [15:0] s_hw;
    logic [31:0] s_ov;
    logic [15:0] s_pos;
    logic [47:0] s_seen;
    bit          s_uns;
    r      = int'(it.reader);
    s_hw   = hiwater;
    s_ov   = overruns;
    s_pos  = rd_pos[r];
    s_seen = rd_seen[r];
    s_uns  = unsynced[r];
    predict(it, unsafe);
    if (unsafe) begin
      hiwater     = s_hw;
      overruns    = s_ov;
      rd_pos[r]   = s_pos;
      rd_seen[r]  = s_seen;
      unsynced[r] = s_uns;
      it.command  = CMD_WRITE;
      typed       = 0;
      predict(it, unsafe);
    end
    if (typed) begin
      staged_q.delete();
      staged_q.push_back(texp);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    foreach (staged_q[i]) result_q.push_back(staged_q[i]);
    // random sender gap
    if (idle_en && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain, let the block settle, then write one register.
  task automatic write_cfg(input logic [1:0] idx, input logic [16:0] val);
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, val);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send(rand_cmd(), 0, '0);
  endtask

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // receiver: check results and stall in bursts
  // --------------------------------------------------------------------------
  initial begin
    out_item_t e;
    out_item_t a;
    out_ch.ready = 1'b0;
    hold_cnt     = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.payload;
        if (result_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0h", $time, a);
          errors++;
        end else begin
          e = result_q.pop_front();
          check_field("status", 32'(e.status), 32'(a.status));
          check_field("data_byte_res", 32'(e.data_byte_res), 32'(a.data_byte_res));
          check_field("last", 32'(e.last), 32'(a.last));
          check_field("copy_len", 32'(e.copy_len), 32'(a.copy_len));
          check_field("reader_backlog", 32'(e.reader_backlog), 32'(a.reader_backlog));
          check_field("max_backlog", 32'(e.max_backlog), 32'(a.max_backlog));
          check_field("overrun_tally", e.overrun_tally, a.overrun_tally);
          check_field("backpressure_count", e.backpressure_count, a.backpressure_count);
        end
      end
      if (hold_req) begin
        hold_cnt = 300;
        hold_req = 0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 18);
      end
      out_ch.ready <= (hold_cnt == 0);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIM) begin
        $display("%0t watchdog expired with %0d results pending", $time, result_q.size());
        $display("FAIL multi_reader_ring_buffer");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    errors        = 0;
    idle_en       = 1;
    hold_req      = 0;
    ring_len      = 17'(DEPTH);
    align_len     = '0;
    head          = '0;
    byte_cnt      = '0;
    hiwater       = '0;
    overruns      = '0;
    bp_events     = '0;
    for (int i = 0; i < READERS; i++) begin
      unsynced[i] = 1;
      rd_pos[i]   = '0;
      rd_seen[i]  = '0;
    end

    // directed rows; expectations typed where they are obvious
    dir_tbl.push_back('{mk(CMD_REPORT, 8'h00, 3'd0, 7'd0, 1'b0), 1'b1,
                        '{ST_ACK, 8'h00, 1'b1, 7'd0, 17'd0, 16'd0, 32'd0, 32'd0}});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd0, 7'd8, 1'b0), 1'b1,
                        '{ST_SYNC, 8'h00, 1'b1, 7'd0, 17'd0, 16'd0, 32'd0, 32'd0}});
    dir_tbl.push_back('{mk(CMD_BACKP, 8'h00, 3'd7, 7'd0, 1'b1), 1'b1,
                        '{ST_BACKPRES, 8'h00, 1'b1, 7'd0, 17'd0, 16'd0, 32'd0, 32'd1}});
    dir_tbl.push_back('{mk(3'd5, 8'hFF, 3'd1, 7'd64, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'h00, 3'd0, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'hFF, 3'd7, 7'd127, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'hA5, 3'd2, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'h5A, 3'd5, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd0, 7'd2, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'hFF, 3'd0, 7'd127, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd0, 7'd64, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'h3C, 3'd0, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd0, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd1, 7'd64, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_ATTACH, 8'h00, 3'd0, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_ATTACH, 8'h00, 3'd7, 7'd0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd0, 7'd1, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_REPORT, 8'h00, 3'd3, 7'd0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(3'd6, 8'h00, 3'd0, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(3'd7, 8'hFF, 3'd7, 7'd127, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_REPORT, 8'h00, 3'd0, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'h7F, 3'd1, 7'd0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_WRITE, 8'h80, 3'd4, 7'd0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk(CMD_READ, 8'h00, 3'd1, 7'd64, 1'b0), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: full ring, no alignment
    foreach (dir_tbl[i]) send(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].exp);
    run_random(50);

    // small ring: frequent laps and overruns
    write_cfg(REG_RING_SIZE, 17'd16);
    run_random(60);

    // one-entry ring with odd alignment
    write_cfg(REG_RING_SIZE, 17'd1);
    write_cfg(REG_ALIGN, 7'd3);
    run_random(25);

    // zero size taken as one; alignment wider than any read
    write_cfg(REG_RING_SIZE, 17'd0);
    write_cfg(REG_ALIGN, 7'd127);
    run_random(20);

    // oversize ring clamps to depth; largest useful alignment
    write_cfg(REG_RING_SIZE, 17'h1FFFF);
    write_cfg(REG_ALIGN, 7'd64);
    run_random(40);

    // odd ring with long receiver hold-off while items keep coming
    write_cfg(REG_RING_SIZE, 17'd37);
    write_cfg(REG_ALIGN, 7'd4);
    hold_req = 1;
    run_random(60);

    // last part with no idling on either side
    idle_en = 0;
    write_cfg(REG_RING_SIZE, 17'd200);
    write_cfg(REG_ALIGN, 7'd0);
    run_random(60);

    // drain and settle
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS multi_reader_ring_buffer");
    end else begin
      $display("FAIL multi_reader_ring_buffer");
    end
    $finish;
  end

endmodule
`default_nettype wire
